>>> rtl/sotq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted one-shot timer queue package
// Shared sizes, request and status codes and the delay-to-tick scaling.
// ----------------------------------------------------------------------------
package sotq_pkg;

    localparam int unsigned TIMER_SLOTS    = 16;
    localparam int unsigned TICK_PERIOD_MS = 10;
    localparam int unsigned MAX_EXPIRE     = 16;

    localparam int unsigned DELAY_W = 24;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned TICK_W  = 48;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned STAT_W  = 3;

    localparam int unsigned IDX_W = $clog2(TIMER_SLOTS);
    localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);
    localparam int unsigned EXP_W = $clog2(MAX_EXPIRE + 1);

    // Exact division by the tick period for any DELAY_W-bit value:
    // q = (x * DIV_MULT) >> DIV_SHIFT with DIV_MULT = ceil(2^DIV_SHIFT / period).
    localparam int unsigned DIV_SHIFT = DELAY_W + $clog2(TICK_PERIOD_MS);
    localparam logic [DELAY_W:0] DIV_MULT =
        (DELAY_W + 1)'(((64'd1 << DIV_SHIFT) + 64'(TICK_PERIOD_MS) - 64'd1)
                       / 64'(TICK_PERIOD_MS));
    localparam int unsigned PROD_W = 2 * DELAY_W + 1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIME = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd4;

endpackage

>>> rtl/sotq_tick_conv.sv
// ----------------------------------------------------------------------------
// Delay to tick converter
// Scales a millisecond delay to whole ticks by a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module sotq_tick_conv (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [sotq_pkg::DELAY_W-1:0] delay_ms,
    output logic [sotq_pkg::DELAY_W-1:0] ticks
);

    logic [sotq_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= sotq_pkg::PROD_W'(delay_ms) * sotq_pkg::PROD_W'(sotq_pkg::DIV_MULT);
        end
    end

    // drop the fraction bits
    assign ticks = sotq_pkg::DELAY_W'(prod_reg >> sotq_pkg::DIV_SHIFT);

endmodule

>>> rtl/sorted_oneshot_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted one-shot timer queue
// Holds one-shot timers sorted by due tick; add, delete and expire on request.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request word at a time. s_tuser carries the
//   request kind (add, delete, time advance); s_tdata carries the delay in ms,
//   the id to delete and the new absolute tick. Each add or delete returns one
//   word on the master channel (status in m_tuser, id in m_tdata, tlast high).
//   A time advance returns one expired word per due timer, earliest first,
//   with tlast on the final one, and no word when nothing is due.
//   Work goes through one shared 48-bit compare and a single slot read port,
//   one slot per cycle: an add walks the queue down from the tail, a delete
//   scans from the head and then shifts the later timers down, and a time
//   advance shifts the queue once for each expired timer.
//   s_tready is high only while the sequencer is idle; one request is in
//   flight at a time.
//   A stalled master side holds the result word and parks the sequencer.
//   Reset empties the queue, sets the current tick to 1 and the next id to 1;
//   slot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_oneshot_timer_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // delay_ms[23:0], timer_id[55:24], now_tick[103:56]
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // result_id[31:0]
    output logic [2:0]   m_tuser,   // status[2:0]
    output logic         m_tlast
);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ADD_MUL   = 3'd1;
    localparam logic [2:0] S_ADD_SUM   = 3'd2;
    localparam logic [2:0] S_ADD_WALK  = 3'd3;
    localparam logic [2:0] S_DEL_SCAN  = 3'd4;
    localparam logic [2:0] S_SHIFT     = 3'd5;
    localparam logic [2:0] S_TIME_HEAD = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    localparam int unsigned IDX_W = sotq_pkg::IDX_W;
    localparam int unsigned CNT_W = sotq_pkg::CNT_W;
    localparam int unsigned EXP_W = sotq_pkg::EXP_W;
    localparam int unsigned ID_W  = sotq_pkg::ID_W;
    localparam int unsigned TICK_W = sotq_pkg::TICK_W;

    // unpack the request word
    logic [sotq_pkg::REQ_W-1:0]   in_req;
    logic [sotq_pkg::DELAY_W-1:0] in_delay;
    logic [ID_W-1:0]              in_id;
    logic [TICK_W-1:0]            in_now;

    assign in_req   = s_tuser;
    assign in_delay = s_tdata[23:0];
    assign in_id    = s_tdata[55:24];
    assign in_now   = s_tdata[103:56];

    // slot storage, one read and one write per cycle
    logic [ID_W-1:0]   ids_reg  [sotq_pkg::TIMER_SLOTS];
    logic [TICK_W-1:0] dues_reg [sotq_pkg::TIMER_SLOTS];

    // control and working registers
    logic [2:0]                  state_reg,   state_next;
    logic [sotq_pkg::REQ_W-1:0]  req_reg,     req_next;
    logic [CNT_W-1:0]            cnt_reg,     cnt_next;
    logic [CNT_W-1:0]            ptr_reg,     ptr_next;
    logic [EXP_W-1:0]            nexp_reg,    nexp_next;
    logic                        pend_reg,    pend_next;
    logic [TICK_W-1:0]           cur_reg,     cur_next;
    logic [ID_W-1:0]             nid_reg,     nid_next;
    logic [TICK_W-1:0]           key_due_reg, key_due_next;
    logic [ID_W-1:0]             key_id_reg,  key_id_next;
    logic [sotq_pkg::STAT_W-1:0] stat_reg,    stat_next;

    // output word register
    logic                        m_tvalid_reg;
    logic [ID_W-1:0]             m_tdata_reg;
    logic [sotq_pkg::STAT_W-1:0] m_tuser_reg;
    logic                        m_tlast_reg;

    logic                        out_load;
    logic [ID_W-1:0]             out_id;
    logic [sotq_pkg::STAT_W-1:0] out_stat;
    logic                        out_last;
    logic                        out_free;

    logic                        s_accept;
    logic [CNT_W-1:0]            rd_ptr;
    logic [ID_W-1:0]             rd_id;
    logic [TICK_W-1:0]           rd_due;
    logic                        rd_gt;
    logic                        due_now;

    logic                        wr_en;
    logic [CNT_W-1:0]            wr_ptr;
    logic [ID_W-1:0]             wr_id;
    logic [TICK_W-1:0]           wr_due;

    logic                        conv_load;
    logic [sotq_pkg::DELAY_W-1:0] conv_ticks;
    logic [ID_W-1:0]             nid_inc;

    sotq_tick_conv u_conv (
        .aclk     (aclk),
        .load     (conv_load),
        .delay_ms (in_delay),
        .ticks    (conv_ticks)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign conv_load = s_accept && (in_req == sotq_pkg::REQ_ADD);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // next id counts modulo 2^32 and skips zero
    assign nid_inc = nid_reg + ID_W'(1);

    // single read port: pick the slot this state looks at
    always_comb begin
        rd_ptr = '0;
        unique case (state_reg)
            S_ADD_WALK: rd_ptr = ptr_reg - CNT_W'(1);
            S_DEL_SCAN: rd_ptr = ptr_reg;
            S_SHIFT:    rd_ptr = ptr_reg + CNT_W'(1);
            default:    rd_ptr = '0;
        endcase
    end

    assign rd_id  = ids_reg[rd_ptr[IDX_W-1:0]];
    assign rd_due = dues_reg[rd_ptr[IDX_W-1:0]];

    // the shared compare: slot due tick against the key tick
    assign rd_gt = rd_due > key_due_reg;

    // head timer expires on this pass
    assign due_now = (cnt_reg != '0) && (nexp_reg < EXP_W'(sotq_pkg::MAX_EXPIRE)) && !rd_gt;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        nexp_next    = nexp_reg;
        pend_next    = pend_reg;
        cur_next     = cur_reg;
        nid_next     = nid_reg;
        key_due_next = key_due_reg;
        key_id_next  = key_id_reg;
        stat_next    = stat_reg;
        wr_en        = 1'b0;
        wr_ptr       = ptr_reg;
        wr_id        = rd_id;
        wr_due       = rd_due;
        out_load     = 1'b0;
        out_id       = key_id_reg;
        out_stat     = stat_reg;
        out_last     = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    req_next = in_req;
                    unique case (in_req)
                        sotq_pkg::REQ_ADD: begin
                            if (cnt_reg == CNT_W'(sotq_pkg::TIMER_SLOTS)) begin
                                stat_next   = sotq_pkg::ST_FULL;
                                key_id_next = '0;
                                state_next  = S_EMIT;
                            end else begin
                                key_id_next = nid_reg;
                                nid_next    = (nid_inc == '0) ? ID_W'(1) : nid_inc;
                                state_next  = S_ADD_MUL;
                            end
                        end
                        sotq_pkg::REQ_DEL: begin
                            key_id_next = in_id;
                            ptr_next    = '0;
                            state_next  = S_DEL_SCAN;
                        end
                        sotq_pkg::REQ_TIME: begin
                            cur_next     = in_now;
                            key_due_next = in_now;
                            nexp_next    = '0;
                            pend_next    = 1'b0;
                            state_next   = S_TIME_HEAD;
                        end
                        default: begin
                            // unused kind: drop the word
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD_MUL: begin
                // product already sits in the converter register
                state_next = S_ADD_SUM;
            end

            S_ADD_SUM: begin
                key_due_next = cur_reg + TICK_W'(conv_ticks);
                ptr_next     = cnt_reg;
                state_next   = S_ADD_WALK;
            end

            S_ADD_WALK: begin
                // walk down from the tail, moving later timers up one slot
                wr_en = 1'b1;
                if ((ptr_reg != '0) && rd_gt) begin
                    ptr_next = ptr_reg - CNT_W'(1);
                end else begin
                    wr_id      = key_id_reg;
                    wr_due     = key_due_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    stat_next  = sotq_pkg::ST_ADDED;
                    state_next = S_EMIT;
                end
            end

            S_DEL_SCAN: begin
                if (ptr_reg < cnt_reg) begin
                    if (rd_id == key_id_reg) begin
                        stat_next  = sotq_pkg::ST_DELETED;
                        state_next = S_SHIFT;
                    end else begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                end else begin
                    stat_next   = sotq_pkg::ST_NOT_FOUND;
                    key_id_next = '0;
                    state_next  = S_EMIT;
                end
            end

            S_SHIFT: begin
                // close the gap at ptr, one slot per cycle
                if ((ptr_reg + CNT_W'(1)) < cnt_reg) begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end else begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = (req_reg == sotq_pkg::REQ_TIME) ? S_TIME_HEAD : S_EMIT;
                end
            end

            S_TIME_HEAD: begin
                if (!pend_reg || out_free) begin
                    if (pend_reg) begin
                        out_load = 1'b1;
                        out_stat = sotq_pkg::ST_EXPIRED;
                        out_last = !due_now;
                    end
                    if (due_now) begin
                        key_id_next = rd_id;
                        pend_next   = 1'b1;
                        nexp_next   = nexp_reg + EXP_W'(1);
                        ptr_next    = '0;
                        state_next  = S_SHIFT;
                    end else begin
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            req_reg      <= sotq_pkg::REQ_ADD;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            nexp_reg     <= '0;
            pend_reg     <= 1'b0;
            cur_reg      <= TICK_W'(1);
            nid_reg      <= ID_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            req_reg   <= req_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            nexp_reg  <= nexp_next;
            pend_reg  <= pend_next;
            cur_reg   <= cur_next;
            nid_reg   <= nid_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_due_reg <= key_due_next;
        key_id_reg  <= key_id_next;
        stat_reg    <= stat_next;
        if (out_load) begin
            m_tdata_reg <= out_id;
            m_tuser_reg <= out_stat;
            m_tlast_reg <= out_last;
        end
        if (wr_en) begin
            ids_reg[wr_ptr[IDX_W-1:0]]  <= wr_id;
            dues_reg[wr_ptr[IDX_W-1:0]] <= wr_due;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(sotq_pkg::TIMER_SLOTS))
        else $error("timer count beyond slot count");

    a_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        nid_reg != '0)
        else $error("next id is zero");

    a_full_keeps_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_req == sotq_pkg::REQ_ADD)
         && (cnt_reg == CNT_W'(sotq_pkg::TIMER_SLOTS))) |=> $stable(nid_reg))
        else $error("full add advanced the next id");

    a_expire_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nexp_reg <= EXP_W'(sotq_pkg::MAX_EXPIRE))
        else $error("too many expiries in one time advance");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result word overwritten while stalled");

endmodule
